// ===== src/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the go-back-N sender window control.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int unsigned SEQ_SPACE = 16;
	localparam int unsigned SEQ_W     = $clog2(SEQ_SPACE);

	localparam logic [SEQ_W-1:0] WINDOW_RESET = SEQ_W'(7);

	typedef enum logic [1:0] {
		OP_SEND = 2'd0,
		OP_ACK  = 2'd1,
		OP_TMO  = 2'd2
	} op_t;

	// one result item
	typedef struct packed {
		logic             send_valid;
		logic [SEQ_W-1:0] send_slot;
		logic             accepted;
		logic             timer_start;
		logic             timer_stop;
		logic [SEQ_W-1:0] in_flight;
		logic             last;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic load_retx;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic retx_begin;
		logic retx_last;
	} dp_sts_t;

endpackage

// ===== src/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Handshake and sequencing control: takes items, steps retransmit bursts and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module gbn_ctrl
	import gbn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RETX = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	logic   retx_step;

	// result register can take a new item when empty or being drained
	assign out_free  = !out_valid_q || m_tready;
	assign accept    = (state_q == ST_IDLE) && out_free && s_tvalid;
	assign retx_step = (state_q == ST_RETX) && out_free;

	assign s_tready      = (state_q == ST_IDLE) && out_free;
	assign m_tvalid      = out_valid_q;
	assign cmd.load_item = accept;
	assign cmd.load_retx = retx_step;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && sts.retx_begin) state_d = ST_RETX;
			end
			ST_RETX: begin
				if (retx_step && sts.retx_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept || retx_step) out_valid_q <= 1'b1;
			else if (m_tready)       out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/gbn_dp.sv =====
// ----------------------------------------------------------------------------
// gbn_dp
// Window datapath: base and next sequence registers, window size register,
// result register and the retransmit index.
// ----------------------------------------------------------------------------
module gbn_dp
	import gbn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [SEQ_W-1:0] cfg_data,
	input  logic [1:0]       operation,
	input  logic [SEQ_W-1:0] ack_seq,
	input  logic [7:0]       ack_type,
	input  logic [7:0]       ack_checksum,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output res_t             res
);

	logic [SEQ_W-1:0] window_size_q;
	logic [SEQ_W-1:0] window_base_q;
	logic [SEQ_W-1:0] next_seq_q;
	logic [SEQ_W-1:0] retx_idx_q;
	res_t             res_q;

	logic [SEQ_W-1:0] inf;
	logic [SEQ_W-1:0] ack_off;
	logic [SEQ_W-1:0] ack_next;
	logic [SEQ_W-1:0] ack_left;
	logic             ack_ok;
	logic             grant;
	logic             ack_take;
	res_t             item_res;
	res_t             retx_res;

	assign inf      = next_seq_q - window_base_q;
	assign grant    = inf < window_size_q;
	assign ack_ok   = (ack_checksum ^ {{(8-SEQ_W){1'b0}}, ack_seq} ^ ack_type) == 8'd0;
	assign ack_off  = ack_seq - window_base_q;
	assign ack_take = ack_ok && (ack_off < inf);
	assign ack_next = ack_seq + SEQ_W'(1);
	assign ack_left = next_seq_q - ack_next;

	assign sts.retx_begin = (op_t'(operation) == OP_TMO) && (inf > SEQ_W'(1));
	assign sts.retx_last  = retx_idx_q == (inf - SEQ_W'(1));

	always_comb begin
		item_res           = '0;
		item_res.in_flight = inf;
		item_res.last      = 1'b1;
		unique case (op_t'(operation))
			OP_SEND: begin
				if (grant) begin
					item_res.send_valid  = 1'b1;
					item_res.send_slot   = next_seq_q;
					item_res.accepted    = 1'b1;
					item_res.timer_start = inf == '0;
					item_res.in_flight   = inf + SEQ_W'(1);
				end
			end
			OP_ACK: begin
				if (ack_take) begin
					item_res.accepted   = 1'b1;
					item_res.timer_stop = ack_left == '0;
					item_res.in_flight  = ack_left;
				end
			end
			OP_TMO: begin
				// first slot of the burst goes out with the item itself
				if (inf != '0) begin
					item_res.send_valid  = 1'b1;
					item_res.send_slot   = window_base_q;
					item_res.timer_start = inf == SEQ_W'(1);
					item_res.last        = inf == SEQ_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		retx_res             = '0;
		retx_res.send_valid  = 1'b1;
		retx_res.send_slot   = window_base_q + retx_idx_q;
		retx_res.timer_start = sts.retx_last;
		retx_res.in_flight   = inf;
		retx_res.last        = sts.retx_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RESET;
			window_base_q <= '0;
			next_seq_q    <= '0;
			retx_idx_q    <= '0;
		end else begin
			if (cfg_we) window_size_q <= cfg_data;
			if (cmd.load_item) begin
				retx_idx_q <= SEQ_W'(1);
				if (op_t'(operation) == OP_SEND && grant) next_seq_q <= next_seq_q + SEQ_W'(1);
				if (op_t'(operation) == OP_ACK && ack_take) window_base_q <= ack_next;
			end else if (cmd.load_retx) begin
				retx_idx_q <= retx_idx_q + SEQ_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item)      res_q <= item_res;
		else if (cmd.load_retx) res_q <= retx_res;
	end

	assign res = res_q;

endmodule

// ===== src/go_back_n_sender_window.sv =====
// A result appears in the output register in the cycle after its item is accepted.
// Send, acknowledgment and unused-code items are taken when the result register is free.
// A timer expiry with N outstanding slots yields N results, one retransmit result per
// cycle while the shared result register is free, then frees the input.
// Reset (arst_n low, asynchronous): window base and next sequence clear to zero,
// window size returns to 7, no result pending.
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-back-N sender window control with modulo-16 sequence numbers.
// ----------------------------------------------------------------------------
module go_back_n_sender_window
	import gbn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,   // window_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // ack_seq[3:0], ack_type[11:4], ack_checksum[19:12]
	input  logic [1:0]  s_tuser,    // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // send_valid[0], send_slot[4:1], accepted[5],
	                                // timer_start[6], timer_stop[7], in_flight[11:8]
	output logic        m_tlast     // last
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	res_t    res;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gbn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.operation    (s_tuser),
		.ack_seq      (s_tdata[3:0]),
		.ack_type     (s_tdata[11:4]),
		.ack_checksum (s_tdata[19:12]),
		.cmd          (cmd),
		.sts          (sts),
		.res          (res)
	);

	assign m_tdata = {4'b0000, res.in_flight, res.timer_stop, res.timer_start,
	                  res.accepted, res.send_slot, res.send_valid};
	assign m_tlast = res.last;

endmodule

// ===== src/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks for the go-back-N sender window, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// hold a pending item until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	// never take an item unless the result register can be loaded
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input ready while result register is blocked");

	a_nosend_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tlast)
		else $error("result without a send slot is not last");

	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tlast)
		else $error("timer start on a result that is not last");

	a_stop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[11:8] == 4'd0)
		else $error("timer stop with packets still in flight");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the go-back-N sender window. Directed tests cover the
// empty, zero and full window cases, bad and stale acknowledgments, timer
// expiry and the unused operation code. Random traffic under several window
// sizes follows, with gaps on both sides and one long receiver hold-off.
// A local window predictor queues the expected result items; every output
// item is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;
	import gbn_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // ack_seq[3:0], ack_type[11:4], ack_checksum[19:12]
	logic [1:0]  s_tuser;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // send_valid[0], send_slot[4:1], accepted[5],
	                        // timer_start[6], timer_stop[7], in_flight[11:8]
	logic        m_tlast;   // last

	// predictor state
	logic [3:0] pred_base;
	logic [3:0] pred_next_seq;
	logic [3:0] pred_window;
	res_t       expected_results[$];

	int mismatches;
	bit tx_idle_en;
	bit rx_idle_en;
	int rx_hold;

	go_back_n_sender_window i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1000000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Queue the result items that one accepted item causes and advance the window.
	function automatic void predict_window(input logic [1:0] op, input logic [3:0] seq,
			input logic [7:0] typ, input logic [7:0] cks);
		res_t       r;
		logic [3:0] inf;
		logic [3:0] off;
		logic [3:0] left;
		inf = pred_next_seq - pred_base;
		r = '0;
		r.in_flight = inf;
		r.last = 1'b1;
		case (op)
			OP_SEND: begin
				if (inf < pred_window) begin
					r.send_valid  = 1'b1;
					r.send_slot   = pred_next_seq;
					r.accepted    = 1'b1;
					r.timer_start = (inf == 4'd0);
					r.in_flight   = inf + 4'd1;
					pred_next_seq = pred_next_seq + 4'd1;
				end
				expected_results.push_back(r);
			end
			OP_ACK: begin
				off = seq - pred_base;
				// only numbers inside the outstanding range slide the base
				if ((cks ^ {4'b0, seq} ^ typ) == 8'd0 && off < inf) begin
					pred_base    = seq + 4'd1;
					left         = pred_next_seq - pred_base;
					r.accepted   = 1'b1;
					r.timer_stop = (left == 4'd0);
					r.in_flight  = left;
				end
				expected_results.push_back(r);
			end
			OP_TMO: begin
				if (inf == 4'd0) begin
					expected_results.push_back(r);
				end else begin
					for (int k = 0; k < int'(inf); k++) begin
						r.send_valid  = 1'b1;
						r.send_slot   = pred_base + 4'(k);
						r.timer_start = (k == int'(inf) - 1);
						r.last        = (k == int'(inf) - 1);
						expected_results.push_back(r);
					end
				end
			end
			default: begin
				expected_results.push_back(r);
			end
		endcase
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// output side: compare every accepted result item with the oldest expectation
	initial begin : result_check
		res_t got;
		res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.send_valid  = m_tdata[0];
				got.send_slot   = m_tdata[4:1];
				got.accepted    = m_tdata[5];
				got.timer_start = m_tdata[6];
				got.timer_stop  = m_tdata[7];
				got.in_flight   = m_tdata[11:8];
				got.last        = m_tlast;
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result item expected none, actual %h", $time, got);
				end else begin
					want = expected_results.pop_front();
					check_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
					check_field("send_slot", 32'(want.send_slot), 32'(got.send_slot));
					check_field("accepted", 32'(want.accepted), 32'(got.accepted));
					check_field("timer_start", 32'(want.timer_start),
						32'(got.timer_start));
					check_field("timer_stop", 32'(want.timer_stop), 32'(got.timer_stop));
					check_field("in_flight", 32'(want.in_flight), 32'(got.in_flight));
					check_field("last", 32'(want.last), 32'(got.last));
				end
			end
		end
	end

	// output ready: random stalls, plus a counted hold-off on request
	initial begin : rx_ready_gen
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_en && $urandom_range(0, 99) < 30)
					stall = pick_gap();
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [3:0] seq,
			input logic [7:0] typ, input logic [7:0] cks);
		int gap;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, cks, typ, seq};
		do begin
			@(posedge clk);
		end while (!s_tready);
		predict_window(op, seq, typ, cks);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_window(input logic [3:0] w);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_we   <= 1'b0;
		pred_window = w;
	endtask

	task automatic send_good_ack(input logic [3:0] seq, input logic [7:0] typ);
		send_item(OP_ACK, seq, typ, typ ^ {4'b0, seq});
	endtask

	// Mostly well-formed traffic: acks aimed inside the outstanding range.
	task automatic send_random_item();
		logic [1:0] op;
		logic [3:0] seq;
		logic [7:0] typ;
		logic [7:0] cks;
		logic [3:0] inf;
		int         r;
		inf = pred_next_seq - pred_base;
		seq = 4'($urandom_range(0, 15));
		typ = 8'($urandom_range(0, 255));
		cks = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			op = OP_SEND;
		end else if (r < 85) begin
			op = OP_ACK;
			r = $urandom_range(0, 99);
			if (r < 70 && inf != 4'd0)
				seq = pred_base + 4'($urandom_range(0, int'(inf) - 1));
			if (r < 85)
				cks = typ ^ {4'b0, seq};
		end else if (r < 95) begin
			op = OP_TMO;
		end else begin
			op = OP_UNUSED;
		end
		send_item(op, seq, typ, cks);
	endtask

	task automatic test_basic_ops();
		send_item(OP_TMO, 4'd0, 8'd0, 8'd0);       // expiry with empty window
		send_good_ack(4'd0, 8'h11);                // nothing outstanding
		send_item(OP_UNUSED, 4'hF, 8'hFF, 8'hFF);
		send_item(OP_SEND, 4'd0, 8'd0, 8'd0);
		send_item(OP_SEND, 4'd0, 8'd0, 8'd0);
		send_item(OP_ACK, 4'd0, 8'h5A, 8'h00);     // bad checksum
		send_good_ack(4'd9, 8'h03);                // outside outstanding range
		send_good_ack(4'd0, 8'hFF);
		send_item(OP_TMO, 4'd0, 8'd0, 8'd0);
		send_good_ack(4'd1, 8'h80);                // clears the window
	endtask

	task automatic test_zero_window();
		set_window(4'd0);
		send_item(OP_SEND, 4'd0, 8'd0, 8'd0);
	endtask

	task automatic test_full_window();
		set_window(4'd15);
		repeat (16) send_item(OP_SEND, 4'd0, 8'd0, 8'd0);
		send_item(OP_TMO, 4'd0, 8'd0, 8'd0);        // fifteen retransmits
		send_good_ack(pred_next_seq - 4'd1, 8'hA5);
	endtask

	task automatic test_random_traffic(input logic [3:0] w, input int count,
			input bit idles);
		set_window(w);
		tx_idle_en = idles;
		rx_idle_en = idles;
		repeat (count) send_random_item();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Hold the output off while the input keeps offering items back to back.
	task automatic test_backpressure();
		set_window(4'd15);
		tx_idle_en = 1'b0;
		rx_hold = 80;
		repeat (30) send_random_item();
		tx_idle_en = 1'b1;
	endtask

	initial begin
		mismatches    = 0;
		tx_idle_en    = 1'b1;
		rx_idle_en    = 1'b1;
		rx_hold       = 0;
		pred_base     = 4'd0;
		pred_next_seq = 4'd0;
		pred_window   = WINDOW_RESET;
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_data <= 4'd0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_zero_window();
		test_full_window();
		test_random_traffic(4'd1, 60, 1'b1);
		test_random_traffic(4'd15, 60, 1'b1);
		test_random_traffic(4'd4, 60, 1'b0);
		test_random_traffic(4'($urandom_range(2, 14)), 60, 1'b1);
		test_random_traffic(4'd7, 60, 1'b1);
		test_backpressure();
		test_random_traffic(4'd3, 30, 1'b1);

		drain_results();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
